### sv/eacu_pkg.sv
// Shared types, widths and constants of the edge-aware column upsampler.
// No dependencies; every other file refers to it by scoped names.
package eacu_pkg;

  localparam int COORD_W   = 24;
  localparam int INT_W     = 16;
  localparam int ROWS      = 32;
  localparam int MAX_SCALE = 8;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SCL_W     = $clog2(MAX_SCALE + 1);
  localparam int THR_W     = 16;
  localparam int OROW_W    = 8;
  localparam int KIND_W    = 3;
  localparam int LANE_W    = COORD_W + 1;
  localparam int NLANE     = 4;
  localparam int PROD_W    = LANE_W + SCL_W;
  localparam int RCP_W     = 32;
  localparam int SUM_W     = 2 * COORD_W + 2;
  localparam int RNG_W     = COORD_W + 1;
  localparam int RB_W      = (ROW_W + SCL_W + 1 > OROW_W) ? ROW_W + SCL_W + 1 : OROW_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 1'd1;

  localparam logic [SCL_W-1:0] SCALE_RST = SCL_W'(3);
  localparam logic [THR_W-1:0] THR_RST   = THR_W'(500);

  localparam logic [KIND_W-1:0] KIND_ORIG   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INTERP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEAR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INT_W-1:0]          inten;
    logic                      inv;
    logic [RNG_W-1:0]          rng;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INT_W-1:0]          inten;
    logic                      inv;
    logic [OROW_W-1:0]         row;
    logic [KIND_W-1:0]         kind;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  // floor(2^32 / s); the quotient estimate is at most one low
  function automatic logic [RCP_W-1:0] recip(input logic [SCL_W-1:0] s);
    logic [RCP_W-1:0] r;
    case (int'(s))
      2:       r = 32'd2147483648;
      3:       r = 32'd1431655765;
      4:       r = 32'd1073741824;
      5:       r = 32'd858993459;
      6:       r = 32'd715827882;
      7:       r = 32'd613566756;
      8:       r = 32'd536870912;
      9:       r = 32'd477218588;
      10:      r = 32'd429496729;
      11:      r = 32'd390451572;
      12:      r = 32'd357913941;
      13:      r = 32'd330382099;
      14:      r = 32'd306783378;
      15:      r = 32'd286331153;
      16:      r = 32'd268435456;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [LANE_W-1:0] lane(input pt_t p, input int k);
    logic signed [LANE_W-1:0] v;
    case (k)
      0:       v = LANE_W'(p.x);
      1:       v = LANE_W'(p.y);
      2:       v = LANE_W'(p.z);
      default: v = $signed({{(LANE_W-INT_W){1'b0}}, p.inten});
    endcase
    return v;
  endfunction

endpackage

### sv/edge_aware_column_upsampler.sv
// Edge-aware column upsampler: Usage
// Input channel (in_valid_i / in_stall_o) takes one lidar point per request,
// rows of one column in order. Output channel (out_valid_o / out_stall_i)
// delivers scale results per point, one only for the first row (plus scale-1
// tail copies after the last row), with last_of_run_o on each point's last one.
// Config writes (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
// scale, index 1 sets edge_threshold_mm; write only while idle.
// Flow: the front end takes a point, squares the coordinates one at a time on
// the shared squaring multiplier, runs the bit-serial square root and queues
// the point, taking no new point until then. The back end emits each copy,
// zero or original result directly, and computes each interpolated one first
// in its multiply, reciprocal and correction steps.
// A two-entry queue lets the front end work on the next point while the back
// end is still emitting or held by out_stall_i; when the queue fills the
// front end holds in_stall_o high.
// Reset clears the queue, the row counter and the previous point, and loads
// scale 3 and threshold 500; no clearing pass is needed.
// Depends on eacu_pkg, eacu_front, eacu_fifo, eacu_back.
module edge_aware_column_upsampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [eacu_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [eacu_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [eacu_pkg::COORD_W-1:0] point_z_i,
  input  logic [eacu_pkg::INT_W-1:0]          point_intensity_i,
  input  logic                                point_invalid_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [eacu_pkg::COORD_W-1:0] out_x_o,
  output logic signed [eacu_pkg::COORD_W-1:0] out_y_o,
  output logic signed [eacu_pkg::COORD_W-1:0] out_z_o,
  output logic [eacu_pkg::INT_W-1:0]          out_intensity_o,
  output logic                                out_invalid_o,
  output logic [eacu_pkg::OROW_W-1:0]         out_row_o,
  output logic [eacu_pkg::KIND_W-1:0]         out_kind_o,
  output logic                                last_of_run_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [eacu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [eacu_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  logic [eacu_pkg::SCL_W-1:0] scale_q;
  logic [eacu_pkg::THR_W-1:0] thr_q;

  logic                fpush, fpop;
  eacu_pkg::fifo_ctl_t fctl;
  eacu_pkg::fifo_sts_t fsts;
  eacu_pkg::pt_t       fin, fout;
  eacu_pkg::res_t      res;

  assign cfg_ready_o = 1'b1;
  assign fctl        = '{push: fpush, pop: fpop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= eacu_pkg::SCALE_RST;
      thr_q   <= eacu_pkg::THR_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == eacu_pkg::REG_SCALE) scale_q <= cfg_data_i[eacu_pkg::SCL_W-1:0];
      if (cfg_index_i == eacu_pkg::REG_THR)   thr_q   <= cfg_data_i[eacu_pkg::THR_W-1:0];
    end
  end

  eacu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_i        (point_x_i),
    .y_i        (point_y_i),
    .z_i        (point_z_i),
    .inten_i    (point_intensity_i),
    .inv_i      (point_invalid_i),
    .full_i     (fsts.full),
    .push_o     (fpush),
    .pt_o       (fin)
  );

  eacu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fctl),
    .wdata_i (fin),
    .rdata_o (fout),
    .sts_o   (fsts)
  );

  eacu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .thr_i       (thr_q),
    .head_i      (fout),
    .empty_i     (fsts.empty),
    .pop_o       (fpop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign out_x_o         = res.x;
  assign out_y_o         = res.y;
  assign out_z_o         = res.z;
  assign out_intensity_o = res.inten;
  assign out_invalid_o   = res.inv;
  assign out_row_o       = res.row;
  assign out_kind_o      = res.kind;
  assign last_of_run_o   = res.last;

endmodule

### sv/eacu_fifo.sv
// Two-entry queue that decouples the range front end from the row sequencer.
// Depends on eacu_pkg.
module eacu_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eacu_pkg::fifo_ctl_t ctl_i,
  input  eacu_pkg::pt_t       wdata_i,
  output eacu_pkg::pt_t       rdata_o,
  output eacu_pkg::fifo_sts_t sts_o
);

  eacu_pkg::pt_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.push && !ctl_i.pop) cnt_d = cnt_q + 2'd1;
    if (!ctl_i.push && ctl_i.pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (ctl_i.push) wp_q <= ~wp_q;
      if (ctl_i.pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o     = mem_q[rp_q];
  assign sts_o.full  = (cnt_q == 2'd2);
  assign sts_o.empty = (cnt_q == 2'd0);

endmodule

### sv/eacu_front.sv
// Front end: takes one request, squares the coordinates on a shared multiplier
// and finds the range with a bit-serial square root. Depends on eacu_pkg.
module eacu_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [eacu_pkg::COORD_W-1:0] x_i,
  input  logic signed [eacu_pkg::COORD_W-1:0] y_i,
  input  logic signed [eacu_pkg::COORD_W-1:0] z_i,
  input  logic [eacu_pkg::INT_W-1:0]      inten_i,
  input  logic                            inv_i,
  input  logic                            full_i,
  output logic                            push_o,
  output eacu_pkg::pt_t                   pt_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_ROOT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam int SW = eacu_pkg::SUM_W;

  logic [1:0] st_q, st_d;
  logic [1:0] ln_q, ln_d;
  eacu_pkg::pt_t pt_q, pt_d;
  logic [SW-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;

  logic signed [eacu_pkg::COORD_W-1:0] op;
  logic signed [2*eacu_pkg::COORD_W-1:0] sq;
  logic [SW-1:0] trial;

  always_comb begin
    case (ln_q)
      2'd0:    op = pt_q.x;
      2'd1:    op = pt_q.y;
      default: op = pt_q.z;
    endcase
    sq    = op * op;
    trial = res_q + bit_q;
  end

  always_comb begin
    st_d  = st_q;
    ln_d  = ln_q;
    pt_d  = pt_q;
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    push_o = 1'b0;
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          pt_d.x     = x_i;
          pt_d.y     = y_i;
          pt_d.z     = z_i;
          pt_d.inten = inten_i;
          pt_d.inv   = inv_i;
          ln_d  = 2'd0;
          rem_d = '0;
          st_d  = F_SQ;
        end
      end
      F_SQ: begin
        rem_d = rem_q + SW'($unsigned(sq));
        ln_d  = ln_q + 2'd1;
        if (ln_q == 2'd2) begin
          res_d = '0;
          bit_d = SW'(1) << (SW - 2);
          st_d  = F_ROOT;
        end
      end
      F_ROOT: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          pt_d.rng = res_d[eacu_pkg::RNG_W-1:0];
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ln_q  <= ln_d;
    pt_q  <= pt_d;
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign in_stall_o = (st_q != F_IDLE);
  assign pt_o       = pt_q;

endmodule

### sv/eacu_back.sv
// Back end: walks fillers, original and tail copies of one queued point and
// drives the output register. Interpolation uses a reciprocal multiply.
// Depends on eacu_pkg.
module eacu_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [eacu_pkg::SCL_W-1:0]     scale_i,
  input  logic [eacu_pkg::THR_W-1:0]     thr_i,
  input  eacu_pkg::pt_t                  head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output eacu_pkg::res_t                 out_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_RCP  = 3'd2;
  localparam logic [2:0] B_FIX  = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  localparam logic [1:0] PH_FILL = 2'd0;
  localparam logic [1:0] PH_ORIG = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  localparam int LW = eacu_pkg::LANE_W;
  localparam int PW = eacu_pkg::PROD_W;
  localparam int SW = eacu_pkg::SCL_W;
  localparam int NL = eacu_pkg::NLANE;

  logic [2:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [SW-1:0] i_q, i_d;
  logic [eacu_pkg::ROW_W-1:0] row_q, row_d;
  logic zero_q, zero_d, disc_q, disc_d;
  eacu_pkg::pt_t cur_q, cur_d, prev_q, prev_d;
  eacu_pkg::res_t out_q, out_d;
  logic ov_q, ov_d;

  logic [PW-1:0] prod_q [NL];
  logic [PW-1:0] q0_q [NL];
  logic          neg_q [NL];
  logic signed [LW-1:0] lerp_q [NL];

  logic [SW-1:0] s;
  logic free, last_row, fill_end;
  logic [eacu_pkg::RNG_W-1:0] diff;
  logic [eacu_pkg::RB_W-1:0] rbase, rcur;
  eacu_pkg::res_t word;

  always_comb begin
    if (scale_i == '0) s = SW'(1);
    else if (scale_i > SW'(eacu_pkg::MAX_SCALE)) s = SW'(eacu_pkg::MAX_SCALE);
    else s = scale_i;
  end

  assign free     = !ov_q || !out_stall_i;
  assign last_row = (row_q == eacu_pkg::ROW_W'(eacu_pkg::ROWS - 1));
  assign fill_end = (i_q == s - SW'(1));
  assign diff     = (head_i.rng > prev_q.rng) ? head_i.rng - prev_q.rng
                                              : prev_q.rng - head_i.rng;

  always_comb begin
    if (ph_q == PH_FILL) rbase = eacu_pkg::RB_W'(row_q - eacu_pkg::ROW_W'(1)) *
                                 eacu_pkg::RB_W'(s);
    else rbase = eacu_pkg::RB_W'(row_q) * eacu_pkg::RB_W'(s);
    rcur = (ph_q == PH_ORIG) ? rbase : rbase + eacu_pkg::RB_W'(i_q);
  end

  // assemble the result at hand
  always_comb begin
    word.row  = rcur[eacu_pkg::OROW_W-1:0];
    word.x     = cur_q.x;
    word.y     = cur_q.y;
    word.z     = cur_q.z;
    word.inten = cur_q.inten;
    word.inv   = cur_q.inv;
    word.kind  = eacu_pkg::KIND_ORIG;
    word.last  = 1'b0;
    case (ph_q)
      PH_FILL: begin
        word.inv = 1'b0;
        if (zero_q) begin
          word.x = '0; word.y = '0; word.z = '0; word.inten = '0;
          word.kind = eacu_pkg::KIND_ZERO;
        end else if (disc_q) begin
          word.kind = eacu_pkg::KIND_NEAR;
          if ({i_q, 1'b0} < {1'b0, s}) begin
            word.x = prev_q.x; word.y = prev_q.y; word.z = prev_q.z;
            word.inten = prev_q.inten;
          end
        end else begin
          word.x     = lerp_q[0][eacu_pkg::COORD_W-1:0];
          word.y     = lerp_q[1][eacu_pkg::COORD_W-1:0];
          word.z     = lerp_q[2][eacu_pkg::COORD_W-1:0];
          word.inten = lerp_q[3][eacu_pkg::INT_W-1:0];
          word.kind  = eacu_pkg::KIND_INTERP;
        end
      end
      PH_ORIG: word.last = !last_row || (s == SW'(1));
      PH_TAIL: begin
        word.kind = eacu_pkg::KIND_TAIL;
        word.last = fill_end;
      end
      default: word.kind = eacu_pkg::KIND_ORIG;
    endcase
  end

  always_comb begin
    st_d = st_q; ph_d = ph_q; i_d = i_q; row_d = row_q;
    zero_d = zero_q; disc_d = disc_q; cur_d = cur_q; prev_d = prev_q;
    out_d = out_q;
    ov_d  = ov_q && out_stall_i;
    pop_o = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cur_d  = head_i;
          i_d    = SW'(1);
          zero_d = prev_q.inv || head_i.inv;
          disc_d = diff > eacu_pkg::RNG_W'(thr_i);
          if (row_q != '0 && s > SW'(1)) begin
            ph_d = PH_FILL;
            st_d = (zero_d || disc_d) ? B_EMIT : B_MUL;
          end else begin
            ph_d = PH_ORIG;
            st_d = B_EMIT;
          end
        end
      end
      B_MUL: st_d = B_RCP;
      B_RCP: st_d = B_FIX;
      B_FIX: st_d = B_EMIT;
      B_EMIT: begin
        if (free) begin
          out_d = word;
          ov_d  = 1'b1;
          case (ph_q)
            PH_FILL: begin
              if (fill_end) begin
                ph_d = PH_ORIG;
              end else begin
                i_d = i_q + SW'(1);
                if (!zero_q && !disc_q) st_d = B_MUL;
              end
            end
            PH_ORIG: begin
              if (last_row && s > SW'(1)) begin
                ph_d = PH_TAIL;
                i_d  = SW'(1);
              end else begin
                row_d  = last_row ? '0 : row_q + eacu_pkg::ROW_W'(1);
                prev_d = cur_q;
                st_d   = B_IDLE;
              end
            end
            PH_TAIL: begin
              if (fill_end) begin
                row_d  = '0;
                prev_d = cur_q;
                st_d   = B_IDLE;
              end else begin
                i_d = i_q + SW'(1);
              end
            end
            default: st_d = B_IDLE;
          endcase
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  // interpolation lanes: |d|*i, reciprocal estimate, one-step correction
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      logic signed [LW-1:0] d;
      logic [LW-1:0] mag;
      logic [PW+eacu_pkg::RCP_W-1:0] full;
      logic [PW+SW-1:0] q0s;
      logic [PW-1:0] r, q;
      d    = eacu_pkg::lane(cur_q, k) - eacu_pkg::lane(prev_q, k);
      mag  = d[LW-1] ? LW'(-d) : LW'(d);
      full = prod_q[k] * eacu_pkg::recip(s);
      q0s  = q0_q[k] * s;
      r    = prod_q[k] - q0s[PW-1:0];
      q    = (r >= PW'(s)) ? q0_q[k] + PW'(1) : q0_q[k];
      if (st_q == B_MUL) begin
        prod_q[k] <= PW'(mag) * PW'(i_q);
        neg_q[k]  <= d[LW-1];
      end
      if (st_q == B_RCP) q0_q[k] <= full[PW+eacu_pkg::RCP_W-1:eacu_pkg::RCP_W];
      if (st_q == B_FIX) lerp_q[k] <= eacu_pkg::lane(prev_q, k) +
                             (neg_q[k] ? -$signed(q[LW-1:0]) : $signed(q[LW-1:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      ph_q   <= PH_FILL;
      i_q    <= '0;
      row_q  <= '0;
      zero_q <= 1'b0;
      disc_q <= 1'b0;
      prev_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      i_q    <= i_d;
      row_q  <= row_d;
      zero_q <= zero_d;
      disc_q <= disc_d;
      prev_q <= prev_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

### sv/eacu_checker.sv
// Port-level checks on the upsampler outputs, bound to the top level.
// Depends on eacu_pkg and edge_aware_column_upsampler.
module eacu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [eacu_pkg::COORD_W-1:0] out_x_o,
  input logic signed [eacu_pkg::COORD_W-1:0] out_y_o,
  input logic signed [eacu_pkg::COORD_W-1:0] out_z_o,
  input logic [eacu_pkg::INT_W-1:0]          out_intensity_o,
  input logic                                out_invalid_o,
  input logic [eacu_pkg::KIND_W-1:0]         out_kind_o,
  input logic                                last_of_run_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_kind_o))
    else $error("stalled result changed");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == eacu_pkg::KIND_INTERP || out_kind_o == eacu_pkg::KIND_NEAR ||
                    out_kind_o == eacu_pkg::KIND_ZERO) |-> !out_invalid_o && !last_of_run_o)
    else $error("filler flagged invalid or last");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == eacu_pkg::KIND_ZERO |->
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && out_intensity_o == '0)
    else $error("zero filler not zero");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_kind_o <= eacu_pkg::KIND_TAIL)
    else $error("bad result kind");

endmodule

bind edge_aware_column_upsampler eacu_checker u_eacu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_x_o         (out_x_o),
  .out_y_o         (out_y_o),
  .out_z_o         (out_z_o),
  .out_intensity_o (out_intensity_o),
  .out_invalid_o   (out_invalid_o),
  .out_kind_o      (out_kind_o),
  .last_of_run_o   (last_of_run_o)
);

### bench/edge_aware_column_upsampler_test.sv
`timescale 1ns / 100ps
// Self-checking bench for edge_aware_column_upsampler: directed and random lidar columns
// checked against an in-bench predictor of the upsampled column.
// Depends on eacu_pkg and the upsampler RTL.
module edge_aware_column_upsampler_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [eacu_pkg::COORD_W-1:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic [eacu_pkg::INT_W-1:0] pt_inten = '0;
  logic pt_inv = 1'b0;
  logic out_valid, out_stall = 1'b0;
  eacu_pkg::res_t got;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [eacu_pkg::CFG_IDX_W-1:0] cfg_index = eacu_pkg::REG_SCALE;
  logic [eacu_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  edge_aware_column_upsampler uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .point_intensity_i(pt_inten), .point_invalid_i(pt_inv),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(got.x), .out_y_o(got.y), .out_z_o(got.z),
    .out_intensity_o(got.inten), .out_invalid_o(got.inv),
    .out_row_o(got.row), .out_kind_o(got.kind), .last_of_run_o(got.last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [3:0]                   scale_reg = 4'd3;
  logic [eacu_pkg::THR_W-1:0]   thr_reg = 16'd500;
  longint                       prev_x, prev_y, prev_z, prev_inten;
  logic                         prev_inv;
  longint unsigned              prev_range;
  int                           row_cnt;
  eacu_pkg::res_t               expected_points[$];

  int errors = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 85;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint unsigned euclid_range(longint x, longint y, longint z);
    longint unsigned v, r, t;
    v = x * x + y * y + z * z;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void add_point(longint x, longint y, longint z, longint inten,
                                    logic inv, longint row,
                                    logic [eacu_pkg::KIND_W-1:0] kind);
    eacu_pkg::res_t e;
    e.x = eacu_pkg::COORD_W'(x);
    e.y = eacu_pkg::COORD_W'(y);
    e.z = eacu_pkg::COORD_W'(z);
    e.inten = eacu_pkg::INT_W'(inten);
    e.inv = inv;
    e.row = eacu_pkg::OROW_W'(row);
    e.kind = kind;
    e.last = 1'b0;
    expected_points.push_back(e);
  endfunction

  function automatic void predict_upsample(logic signed [eacu_pkg::COORD_W-1:0] px, py, pz,
                                           logic [eacu_pkg::INT_W-1:0] pi, logic pv);
    longint x, y, z, inten, s, base;
    longint unsigned r, diff;
    bit disc;
    x = px;
    y = py;
    z = pz;
    inten = pi;
    s = scale_reg;
    if (s == 0) s = 1;
    if (s > eacu_pkg::MAX_SCALE) s = eacu_pkg::MAX_SCALE;
    r = euclid_range(x, y, z);
    if (row_cnt > 0) begin
      base = (row_cnt - 1) * s;
      diff = (r > prev_range) ? r - prev_range : prev_range - r;
      disc = diff > thr_reg;
      for (longint i = 1; i < s; i++) begin
        if (prev_inv || pv)
          add_point(0, 0, 0, 0, 1'b0, base + i, eacu_pkg::KIND_ZERO);
        else if (disc) begin
          if (2 * i < s)
            add_point(prev_x, prev_y, prev_z, prev_inten, 1'b0, base + i,
                      eacu_pkg::KIND_NEAR);
          else
            add_point(x, y, z, inten, 1'b0, base + i, eacu_pkg::KIND_NEAR);
        end else begin
          add_point(prev_x + ((x - prev_x) * i) / s, prev_y + ((y - prev_y) * i) / s,
                    prev_z + ((z - prev_z) * i) / s,
                    prev_inten + ((inten - prev_inten) * i) / s, 1'b0, base + i,
                    eacu_pkg::KIND_INTERP);
        end
      end
    end
    base = row_cnt * s;
    add_point(x, y, z, inten, pv, base, eacu_pkg::KIND_ORIG);
    if (row_cnt == eacu_pkg::ROWS - 1) begin
      for (longint i = 1; i < s; i++)
        add_point(x, y, z, inten, pv, base + i, eacu_pkg::KIND_TAIL);
      row_cnt = 0;
    end else begin
      row_cnt++;
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
    prev_inten = inten;
    prev_inv = pv;
    prev_range = r;
    expected_points[expected_points.size() - 1].last = 1'b1;
  endfunction

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // compare each result with the oldest expectation
  initial begin
    eacu_pkg::res_t e;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_point(logic signed [eacu_pkg::COORD_W-1:0] x, y, z,
                            logic [eacu_pkg::INT_W-1:0] inten, logic inv);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    pt_x = x;
    pt_y = y;
    pt_z = z;
    pt_inten = inten;
    pt_inv = inv;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_upsample(x, y, z, inten, inv);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [eacu_pkg::CFG_IDX_W-1:0] idx,
                           logic [eacu_pkg::CFG_DAT_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == eacu_pkg::REG_SCALE) scale_reg = data[3:0];
    else thr_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_point();
    logic signed [eacu_pkg::COORD_W-1:0] x, y, z;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // smooth neighbour of the previous row
      x = eacu_pkg::COORD_W'(prev_x + $signed($urandom_range(600)) - 300);
      y = eacu_pkg::COORD_W'(prev_y + $signed($urandom_range(600)) - 300);
      z = eacu_pkg::COORD_W'(prev_z + $signed($urandom_range(600)) - 300);
    end else if (pick < 80) begin
      x = eacu_pkg::COORD_W'($signed($urandom_range(40000)) - 20000);
      y = eacu_pkg::COORD_W'($signed($urandom_range(40000)) - 20000);
      z = eacu_pkg::COORD_W'($signed($urandom_range(4000)) - 2000);
    end else begin
      x = eacu_pkg::COORD_W'($urandom);
      y = eacu_pkg::COORD_W'($urandom);
      z = eacu_pkg::COORD_W'($urandom);
    end
    send_point(x, y, z, eacu_pkg::INT_W'($urandom), $urandom_range(9) == 0);
  endtask

  task automatic test_reset_defaults();
    send_point(1000, 0, 0, 100, 1'b0);
    send_point(1100, 30, -20, 200, 1'b0);
    send_point(5000, 0, 0, 300, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b0);
    send_point(24'sh800000, 24'sh800000, 24'sh800000, 16'h0000, 1'b0);
    send_point(24'sh800000, 24'sh800000, 24'sh800000, 16'hFFFF, 1'b0);
    send_point(0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_invalid_points();
    send_point(-12345, 678, 9, 16'h5A5A, 1'b1);
    send_point(12345, -678, -9, 16'hA5A5, 1'b0);
    send_point(12, 34, 56, 16'h0001, 1'b1);
    send_point(13, 34, 56, 16'h0002, 1'b1);
  endtask

  task automatic test_scale_and_threshold();
    write_reg(eacu_pkg::REG_SCALE, 16'd8);
    write_reg(eacu_pkg::REG_THR, 16'd0);
    send_point(-7, 100, 3, 9, 1'b0);
    send_point(1, 101, -5, 0, 1'b0);
    write_reg(eacu_pkg::REG_THR, 16'hFFFF);
    send_point(-300000, 200000, 7, 60000, 1'b0);
    send_point(7, 5, 3, 1, 1'b0);
    write_reg(eacu_pkg::REG_SCALE, 16'hFFF0);
    send_point(100, 0, 0, 50, 1'b0);
    send_point(200, 0, 0, 60, 1'b0);
    write_reg(eacu_pkg::REG_SCALE, 16'd15);
    send_point(300, 0, 0, 70, 1'b0);
    write_reg(eacu_pkg::REG_SCALE, 16'd1);
    send_point(400, 0, 0, 80, 1'b0);
    write_reg(eacu_pkg::REG_THR, 16'd500);
    write_reg(eacu_pkg::REG_SCALE, 16'd3);
  endtask

  task automatic test_random_phase(int n);
    write_reg(eacu_pkg::REG_SCALE, {12'($urandom_range(4095)), 4'($urandom_range(8, 1))});
    write_reg(eacu_pkg::REG_THR,
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)));
    repeat (n) send_random_point();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req = 1'b1;
    repeat (20) send_random_point();
  endtask

  initial begin
    prev_x = 0;
    prev_y = 0;
    prev_z = 0;
    prev_inten = 0;
    prev_inv = 1'b0;
    prev_range = 0;
    row_cnt = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_invalid_points();
    test_scale_and_threshold();
    test_random_phase(100);
    send_idle_pct = 85;
    recv_idle_pct = 22;
    test_random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(90);
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
